// ===== hw/rtl/sabc_pkg.sv =====
package sabc_pkg;

    // Canvas limits
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = 11;
    localparam int COORD_W = 10;
    localparam int CHAN_W  = 8;
    localparam int OPA_W   = 7;
    localparam int PROD_W  = CHAN_W + OPA_W;

    localparam logic [DIM_W-1:0] DIM_MAX     = DIM_W'(MAX_DIM);
    localparam logic [OPA_W-1:0] OPACITY_MAX = OPA_W'(100);

    // Opacity scaling: (alpha * opacity + 50) / 100 as a reciprocal multiply
    localparam logic [PROD_W-1:0] ROUND_HALF_PCT = PROD_W'(50);
    localparam int                RECIP_W        = 13;
    localparam logic [RECIP_W-1:0] RECIP_100     = RECIP_W'(5243);
    localparam int                RECIP_SHIFT    = 19;
    localparam int                SCALED_W       = PROD_W + RECIP_W;

    // Blend
    localparam logic [CHAN_W-1:0] ALPHA_FULL  = CHAN_W'(255);
    localparam int                BLEND_W     = 2 * CHAN_W;
    localparam int                SUM_W       = BLEND_W + 1;
    localparam logic [SUM_W-1:0]  BLEND_ROUND = SUM_W'(127);
    localparam int                NUM_CHAN    = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register map (word index = paddr[4:2])
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd3;
    localparam logic [2:0] REG_OPACITY       = 3'd4;

    typedef struct packed {
        logic signed [DIM_W-1:0] origin_x;
        logic signed [DIM_W-1:0] origin_y;
        logic [DIM_W-1:0]        canvas_width;
        logic [DIM_W-1:0]        canvas_height;
        logic [OPA_W-1:0]        opacity_percent;
    } t_cfg;

    typedef struct packed {
        logic                write_pixel;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [CHAN_W-1:0]   alpha;
        logic [CHAN_W-1:0]   src_red;
        logic [CHAN_W-1:0]   src_green;
        logic [CHAN_W-1:0]   src_blue;
        logic [CHAN_W-1:0]   dst_red;
        logic [CHAN_W-1:0]   dst_green;
        logic [CHAN_W-1:0]   dst_blue;
    } t_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

// ===== hw/rtl/sabc_front.sv =====
module sabc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sabc_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sabc_pkg::COORD_W-1:0] i_sprite_col,
    input  logic [sabc_pkg::COORD_W-1:0] i_sprite_row,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_red,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_green,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_blue,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_alpha,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_red,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_green,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_blue,
    input  sabc_pkg::t_queue_status      i_qstat,
    output logic                         o_push,
    output sabc_pkg::t_item              o_item
);

    logic                         r_valid;
    logic                         r_inside;
    logic [sabc_pkg::COORD_W-1:0] r_col;
    logic [sabc_pkg::COORD_W-1:0] r_row;
    logic [sabc_pkg::PROD_W-1:0]  r_prod;
    logic [sabc_pkg::CHAN_W-1:0]  r_src_red, r_src_green, r_src_blue;
    logic [sabc_pkg::CHAN_W-1:0]  r_dst_red, r_dst_green, r_dst_blue;

    logic                         f_free;
    logic [sabc_pkg::OPA_W-1:0]   opacity;
    logic [sabc_pkg::DIM_W-1:0]   width;
    logic [sabc_pkg::DIM_W-1:0]   height;
    logic [sabc_pkg::DIM_W:0]     cx;
    logic [sabc_pkg::DIM_W:0]     cy;
    logic                         n_inside;
    logic [sabc_pkg::PROD_W-1:0]  n_prod;
    logic [sabc_pkg::SCALED_W-1:0] scaled;
    logic [sabc_pkg::CHAN_W-1:0]  alpha;

    assign f_free  = !r_valid || !i_qstat.full;
    assign o_stall = !f_free;
    assign o_push  = r_valid && !i_qstat.full;

    // Clamp configuration to its legal range
    assign opacity = (i_cfg.opacity_percent > sabc_pkg::OPACITY_MAX) ?
                     sabc_pkg::OPACITY_MAX : i_cfg.opacity_percent;
    assign width   = (i_cfg.canvas_width > sabc_pkg::DIM_MAX) ?
                     sabc_pkg::DIM_MAX : i_cfg.canvas_width;
    assign height  = (i_cfg.canvas_height > sabc_pkg::DIM_MAX) ?
                     sabc_pkg::DIM_MAX : i_cfg.canvas_height;

    // Offset by origin in one extra bit and clip
    assign cx = {i_cfg.origin_x[sabc_pkg::DIM_W-1], i_cfg.origin_x}
              + {2'b00, i_sprite_col};
    assign cy = {i_cfg.origin_y[sabc_pkg::DIM_W-1], i_cfg.origin_y}
              + {2'b00, i_sprite_row};
    assign n_inside = !cx[sabc_pkg::DIM_W] && !cy[sabc_pkg::DIM_W]
                   && (cx[sabc_pkg::DIM_W-1:0] < width)
                   && (cy[sabc_pkg::DIM_W-1:0] < height);

    assign n_prod = sabc_pkg::PROD_W'(i_src_alpha) * sabc_pkg::PROD_W'(opacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (f_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_free && i_valid) begin
            r_inside    <= n_inside;
            r_col       <= cx[sabc_pkg::COORD_W-1:0];
            r_row       <= cy[sabc_pkg::COORD_W-1:0];
            r_prod      <= n_prod;
            r_src_red   <= i_src_red;
            r_src_green <= i_src_green;
            r_src_blue  <= i_src_blue;
            r_dst_red   <= i_dst_red;
            r_dst_green <= i_dst_green;
            r_dst_blue  <= i_dst_blue;
        end
    end

    // Divide by 100 with rounding: exact over the whole product range
    assign scaled = sabc_pkg::SCALED_W'(r_prod + sabc_pkg::ROUND_HALF_PCT)
                  * sabc_pkg::SCALED_W'(sabc_pkg::RECIP_100);
    assign alpha  = scaled[sabc_pkg::RECIP_SHIFT +: sabc_pkg::CHAN_W];

    always_comb begin
        o_item.write_pixel = r_inside && (alpha != '0);
        o_item.col         = r_col;
        o_item.row         = r_row;
        o_item.alpha       = alpha;
        o_item.src_red     = r_src_red;
        o_item.src_green   = r_src_green;
        o_item.src_blue    = r_src_blue;
        o_item.dst_red     = r_dst_red;
        o_item.dst_green   = r_dst_green;
        o_item.dst_blue    = r_dst_blue;
    end

endmodule

// ===== hw/rtl/sabc_queue.sv =====
module sabc_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  sabc_pkg::t_item         i_item,
    input  logic                    i_pop,
    output sabc_pkg::t_item         o_item,
    output sabc_pkg::t_queue_status o_qstat
);

    sabc_pkg::t_item             r_mem [sabc_pkg::QUEUE_DEPTH];
    logic [sabc_pkg::QPTR_W-1:0] r_wr;
    logic [sabc_pkg::QPTR_W-1:0] r_rd;
    logic [sabc_pkg::QPTR_W:0]   r_count;

    logic [sabc_pkg::QPTR_W-1:0] n_wr;
    logic [sabc_pkg::QPTR_W-1:0] n_rd;

    assign o_qstat.full      = (r_count == (sabc_pkg::QPTR_W + 1)'(sabc_pkg::QUEUE_DEPTH));
    assign o_qstat.not_empty = (r_count != '0);
    assign o_item            = r_mem[r_rd];

    assign n_wr = (r_wr == sabc_pkg::QPTR_W'(sabc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == sabc_pkg::QPTR_W'(sabc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/sabc_back.sv =====
module sabc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sabc_pkg::t_item              i_item,
    input  sabc_pkg::t_queue_status      i_qstat,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_write_pixel,
    output logic [sabc_pkg::COORD_W-1:0] o_canvas_col,
    output logic [sabc_pkg::COORD_W-1:0] o_canvas_row,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_red,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_green,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_blue
);

    logic                          r_b_valid;
    logic                          r_b_write;
    logic [sabc_pkg::COORD_W-1:0]  r_b_col;
    logic [sabc_pkg::COORD_W-1:0]  r_b_row;
    logic [sabc_pkg::BLEND_W-1:0]  r_ps [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::BLEND_W-1:0]  r_pd [sabc_pkg::NUM_CHAN];

    logic                          r_o_valid;
    logic                          r_o_write;
    logic [sabc_pkg::COORD_W-1:0]  r_o_col;
    logic [sabc_pkg::COORD_W-1:0]  r_o_row;
    logic [sabc_pkg::CHAN_W-1:0]   r_o_chan [sabc_pkg::NUM_CHAN];

    logic                          out_free;
    logic                          b_free;
    logic [sabc_pkg::CHAN_W-1:0]   inv_alpha;
    logic [sabc_pkg::CHAN_W-1:0]   src [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::CHAN_W-1:0]   dst [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::BLEND_W-1:0]  n_ps [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::BLEND_W-1:0]  n_pd [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::SUM_W-1:0]    sum [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::SUM_W-1:0]    quo [sabc_pkg::NUM_CHAN];
    logic [sabc_pkg::CHAN_W-1:0]   n_chan [sabc_pkg::NUM_CHAN];

    assign out_free = !r_o_valid || !i_stall;
    assign b_free   = !r_b_valid || out_free;
    assign o_pop    = i_qstat.not_empty && b_free;

    assign inv_alpha = sabc_pkg::ALPHA_FULL - i_item.alpha;
    assign src[0] = i_item.src_red;
    assign src[1] = i_item.src_green;
    assign src[2] = i_item.src_blue;
    assign dst[0] = i_item.dst_red;
    assign dst[1] = i_item.dst_green;
    assign dst[2] = i_item.dst_blue;

    // Per-channel weights; full alpha reduces to a plain copy
    always_comb begin
        for (int i = 0; i < sabc_pkg::NUM_CHAN; i++) begin
            n_ps[i] = sabc_pkg::BLEND_W'(src[i]) * sabc_pkg::BLEND_W'(i_item.alpha);
            n_pd[i] = sabc_pkg::BLEND_W'(dst[i]) * sabc_pkg::BLEND_W'(inv_alpha);
        end
    end

    // Rounded divide by 255: q = (x + (x >> 8) + 1) >> 8
    always_comb begin
        for (int i = 0; i < sabc_pkg::NUM_CHAN; i++) begin
            sum[i]    = sabc_pkg::SUM_W'(r_ps[i]) + sabc_pkg::SUM_W'(r_pd[i])
                      + sabc_pkg::BLEND_ROUND;
            quo[i]    = sum[i] + sabc_pkg::SUM_W'(sum[i][sabc_pkg::SUM_W-1:sabc_pkg::CHAN_W])
                      + sabc_pkg::SUM_W'(1);
            n_chan[i] = r_b_write ? quo[i][sabc_pkg::CHAN_W +: sabc_pkg::CHAN_W] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= i_qstat.not_empty;
            end
            if (out_free) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_write <= i_item.write_pixel;
            r_b_col   <= i_item.col;
            r_b_row   <= i_item.row;
            r_ps      <= n_ps;
            r_pd      <= n_pd;
        end
        if (out_free && r_b_valid) begin
            r_o_write <= r_b_write;
            r_o_col   <= r_b_write ? r_b_col : '0;
            r_o_row   <= r_b_write ? r_b_row : '0;
            r_o_chan  <= n_chan;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_write_pixel = r_o_write;
    assign o_canvas_col  = r_o_col;
    assign o_canvas_row  = r_o_row;
    assign o_out_red     = r_o_chan[0];
    assign o_out_green   = r_o_chan[1];
    assign o_out_blue    = r_o_chan[2];

endmodule

// ===== hw/rtl/sprite_alpha_blend_clip_unit.sv =====
// Sprite compositor: source-over blend of one sprite pixel onto the canvas.
//
// Input channel (i_valid / o_stall): one sprite pixel per item, with its
// position inside the sprite, its RGBA value and the canvas RGB under it.
// Output channel (o_valid / i_stall): one result per item, in order. When
// o_write_pixel is low the pixel is clipped or transparent and every other
// result field reads zero.
// Configuration: APB-style port, one 32-bit word per register at 4*index:
// origin x, origin y, canvas width, canvas height, opacity in percent.
// Write registers only while no item is in flight.
//
// Path: front register, queue, then back-end weight and output registers.
// Throughput: one item per cycle while the receiver does not stall, via the
// front stage (clip and alpha scale) and a two-stage back end (channel
// weights, divide by 255). A 4-entry queue sits between front and back, so
// a stalled receiver first fills the queue, then o_stall rises at the input.
// Reset: empties both pipelines and the queue, restores register defaults
// (origin 0,0, canvas 1024 x 1024, opacity 100). No clearing pass is needed.
module sprite_alpha_blend_clip_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sabc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sabc_pkg::DATA_W-1:0]  pwdata,
    output logic [sabc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input items
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sabc_pkg::COORD_W-1:0] i_sprite_col,
    input  logic [sabc_pkg::COORD_W-1:0] i_sprite_row,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_red,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_green,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_blue,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_src_alpha,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_red,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_green,
    input  logic [sabc_pkg::CHAN_W-1:0]  i_dst_blue,
    // result items
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_write_pixel,
    output logic [sabc_pkg::COORD_W-1:0] o_canvas_col,
    output logic [sabc_pkg::COORD_W-1:0] o_canvas_row,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_red,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_green,
    output logic [sabc_pkg::CHAN_W-1:0]  o_out_blue
);

    sabc_pkg::t_cfg          r_cfg;
    logic                    cfg_wr;
    logic [2:0]              reg_idx;

    logic                    push;
    logic                    pop;
    sabc_pkg::t_item         front_item;
    sabc_pkg::t_item         back_item;
    sabc_pkg::t_queue_status qstat;

    // ---------------------------------------------------------------
    // Register file: decode word index, ignore byte offset bits
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x        <= '0;
            r_cfg.origin_y        <= '0;
            r_cfg.canvas_width    <= sabc_pkg::DIM_MAX;
            r_cfg.canvas_height   <= sabc_pkg::DIM_MAX;
            r_cfg.opacity_percent <= sabc_pkg::OPACITY_MAX;
        end else if (cfg_wr) begin
            case (reg_idx)
                sabc_pkg::REG_ORIGIN_X: begin
                    r_cfg.origin_x <= pwdata[sabc_pkg::DIM_W-1:0];
                end
                sabc_pkg::REG_ORIGIN_Y: begin
                    r_cfg.origin_y <= pwdata[sabc_pkg::DIM_W-1:0];
                end
                sabc_pkg::REG_CANVAS_WIDTH: begin
                    r_cfg.canvas_width <= pwdata[sabc_pkg::DIM_W-1:0];
                end
                sabc_pkg::REG_CANVAS_HEIGHT: begin
                    r_cfg.canvas_height <= pwdata[sabc_pkg::DIM_W-1:0];
                end
                sabc_pkg::REG_OPACITY: begin
                    r_cfg.opacity_percent <= pwdata[sabc_pkg::OPA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Return register values; origins read back sign-extended, the rest zero-extended
    always_comb begin
        case (reg_idx)
            sabc_pkg::REG_ORIGIN_X:      prdata = sabc_pkg::DATA_W'(r_cfg.origin_x);
            sabc_pkg::REG_ORIGIN_Y:      prdata = sabc_pkg::DATA_W'(r_cfg.origin_y);
            sabc_pkg::REG_CANVAS_WIDTH:  prdata = sabc_pkg::DATA_W'(r_cfg.canvas_width);
            sabc_pkg::REG_CANVAS_HEIGHT: prdata = sabc_pkg::DATA_W'(r_cfg.canvas_height);
            sabc_pkg::REG_OPACITY:       prdata = sabc_pkg::DATA_W'(r_cfg.opacity_percent);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: accept, clip, scale alpha; classify into write / no write
    // ---------------------------------------------------------------
    sabc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sprite_col (i_sprite_col),
        .i_sprite_row (i_sprite_row),
        .i_src_red    (i_src_red),
        .i_src_green  (i_src_green),
        .i_src_blue   (i_src_blue),
        .i_src_alpha  (i_src_alpha),
        .i_dst_red    (i_dst_red),
        .i_dst_green  (i_dst_green),
        .i_dst_blue   (i_dst_blue),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_item       (front_item)
    );

    // Decouple front and back so each side can stall on its own
    sabc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (back_item),
        .o_qstat (qstat)
    );

    // ---------------------------------------------------------------
    // Back: blend channels and hold the result until taken
    // ---------------------------------------------------------------
    sabc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (back_item),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_write_pixel (o_write_pixel),
        .o_canvas_col  (o_canvas_col),
        .o_canvas_row  (o_canvas_row),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue)
    );

endmodule

// ===== hw/rtl/sabc_checker.sv =====
module sabc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_write_pixel,
    input logic [sabc_pkg::COORD_W-1:0] o_canvas_col,
    input logic [sabc_pkg::COORD_W-1:0] o_canvas_row,
    input logic [sabc_pkg::CHAN_W-1:0]  o_out_red,
    input logic [sabc_pkg::CHAN_W-1:0]  o_out_green,
    input logic [sabc_pkg::CHAN_W-1:0]  o_out_blue
);

    // Pipelines come out of reset empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    // A skipped pixel carries all-zero fields
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_pixel |->
            o_canvas_col == '0 && o_canvas_row == '0 &&
            o_out_red == '0 && o_out_green == '0 && o_out_blue == '0)
        else $error("skipped pixel has nonzero fields");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=>
            $stable(o_write_pixel) && $stable(o_canvas_col) &&
            $stable(o_canvas_row) && $stable(o_out_red) &&
            $stable(o_out_green) && $stable(o_out_blue))
        else $error("result changed while stalled");

endmodule

bind sprite_alpha_blend_clip_unit sabc_checker u_sabc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_write_pixel (o_write_pixel),
    .o_canvas_col  (o_canvas_col),
    .o_canvas_row  (o_canvas_row),
    .o_out_red     (o_out_red),
    .o_out_green   (o_out_green),
    .o_out_blue    (o_out_blue)
);

// ===== dv/sprite_alpha_blend_clip_unit_test.sv =====
`timescale 1ns / 100ps

module sprite_alpha_blend_clip_unit_test;

    // Cycles to let pass after the last result before touching registers or ending,
    // as a margin.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int CALM_PHASE = 3;  // phase run with no idling on either side

    typedef struct packed {
        logic [sabc_pkg::COORD_W-1:0] col;
        logic [sabc_pkg::COORD_W-1:0] row;
        logic [sabc_pkg::CHAN_W-1:0]  src_red;
        logic [sabc_pkg::CHAN_W-1:0]  src_green;
        logic [sabc_pkg::CHAN_W-1:0]  src_blue;
        logic [sabc_pkg::CHAN_W-1:0]  src_alpha;
        logic [sabc_pkg::CHAN_W-1:0]  dst_red;
        logic [sabc_pkg::CHAN_W-1:0]  dst_green;
        logic [sabc_pkg::CHAN_W-1:0]  dst_blue;
    } t_sprite_pixel;

    typedef struct packed {
        logic                         write_pixel;
        logic [sabc_pkg::COORD_W-1:0] col;
        logic [sabc_pkg::COORD_W-1:0] row;
        logic [sabc_pkg::CHAN_W-1:0]  red;
        logic [sabc_pkg::CHAN_W-1:0]  green;
        logic [sabc_pkg::CHAN_W-1:0]  blue;
    } t_blend_result;

    // One directed row: the canvas setup it runs under, the pixel, and a hand-typed
    // result where the answer is obvious (otherwise the predictor supplies it).
    typedef struct packed {
        sabc_pkg::t_cfg setup;
        t_sprite_pixel  px;
        logic           typed;
        t_blend_result  want;
    } t_plan_row;

    // Canvas setups for the directed part: origin x, origin y, width, height, opacity.
    localparam sabc_pkg::t_cfg CFG_DEFAULT   = '{11'd0, 11'd0, 11'd1024, 11'd1024, 7'd100};
    // origin at -1024,-1024: the whole sprite lands left of and above the canvas
    localparam sabc_pkg::t_cfg CFG_FAR_NEG   = '{11'h400, 11'h400, 11'd1024, 11'd1024, 7'd100};
    localparam sabc_pkg::t_cfg CFG_FAR_POS   = '{11'd1023, 11'd1023, 11'd1024, 11'd1024, 7'd100};
    localparam sabc_pkg::t_cfg CFG_ONE_PIX   = '{11'd0, 11'd0, 11'd1, 11'd1, 7'd50};
    localparam sabc_pkg::t_cfg CFG_NO_CANVAS = '{11'd0, 11'd0, 11'd0, 11'd0, 7'd100};
    // sizes and opacity past their limits: both must clamp
    localparam sabc_pkg::t_cfg CFG_OVERSIZE  = '{11'd1, 11'd1, 11'd2047, 11'd2047, 7'd127};
    localparam sabc_pkg::t_cfg CFG_CLEAR     = '{11'd0, 11'd0, 11'd1024, 11'd1024, 7'd0};
    // origin at -1,-1 with the faintest opacity
    localparam sabc_pkg::t_cfg CFG_NUDGE     = '{11'h7FF, 11'h7FF, 11'd1024, 11'd1024, 7'd1};

    localparam t_blend_result NO_WRITE = '0;
    localparam int PLAN_ROWS = 22;

    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        // opaque white at the top left corner: plain copy
        '{CFG_DEFAULT, '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, '{1'b1, 10'd0, 10'd0, 8'hff, 8'hff, 8'hff}},
        // opaque at the bottom right corner
        '{CFG_DEFAULT, '{10'd1023, 10'd1023, 8'h12, 8'h34, 8'h56, 8'hff, 8'hff, 8'hff, 8'hff},
          1'b1, '{1'b1, 10'd1023, 10'd1023, 8'h12, 8'h34, 8'h56}},
        // fully transparent source
        '{CFG_DEFAULT, '{10'd5, 10'd7, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_DEFAULT, '{10'd3, 10'd4, 8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00},
          1'b0, NO_WRITE},
        '{CFG_DEFAULT, '{10'd9, 10'd9, 8'hff, 8'h00, 8'haa, 8'h80, 8'h00, 8'hff, 8'h55},
          1'b0, NO_WRITE},
        '{CFG_DEFAULT, '{10'd200, 10'd300, 8'h00, 8'hff, 8'h0f, 8'hfe, 8'hff, 8'h00, 8'hf0},
          1'b0, NO_WRITE},
        // far negative origin: clipped at both sprite corners
        '{CFG_FAR_NEG, '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_FAR_NEG, '{10'd1023, 10'd1023, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        // far positive origin: only the sprite's first pixel fits
        '{CFG_FAR_POS, '{10'd0, 10'd0, 8'h01, 8'h02, 8'h03, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, '{1'b1, 10'd1023, 10'd1023, 8'h01, 8'h02, 8'h03}},
        '{CFG_FAR_POS, '{10'd1, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_FAR_POS, '{10'd0, 10'd1, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        // one-pixel canvas at half opacity
        '{CFG_ONE_PIX, '{10'd0, 10'd0, 8'hc8, 8'h64, 8'h32, 8'hff, 8'h10, 8'h20, 8'h30},
          1'b0, NO_WRITE},
        '{CFG_ONE_PIX, '{10'd1, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_ONE_PIX, '{10'd0, 10'd1, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_ONE_PIX, '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00},
          1'b0, NO_WRITE},
        // empty canvas clips everything
        '{CFG_NO_CANVAS, '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        // oversize canvas clamps to the maximum dimension
        '{CFG_OVERSIZE, '{10'd1022, 10'd1022, 8'h09, 8'h08, 8'h07, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, '{1'b1, 10'd1023, 10'd1023, 8'h09, 8'h08, 8'h07}},
        '{CFG_OVERSIZE, '{10'd1023, 10'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_OVERSIZE, '{10'd10, 10'd10, 8'hff, 8'h80, 8'h00, 8'h64, 8'h00, 8'h80, 8'hff},
          1'b0, NO_WRITE},
        // zero opacity: nothing is ever written
        '{CFG_CLEAR, '{10'd4, 10'd4, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE},
        '{CFG_NUDGE, '{10'd1, 10'd1, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b0, NO_WRITE},
        '{CFG_NUDGE, '{10'd0, 10'd5, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00},
          1'b1, NO_WRITE}
    };

    // Clock, reset and every block input start at known values.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sabc_pkg::ADDR_W-1:0] paddr = '0;
    logic [sabc_pkg::DATA_W-1:0] pwdata = '0;
    logic [sabc_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [sabc_pkg::COORD_W-1:0] i_sprite_col = '0;
    logic [sabc_pkg::COORD_W-1:0] i_sprite_row = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_src_red = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_src_green = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_src_blue = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_src_alpha = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_dst_red = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_dst_green = '0;
    logic [sabc_pkg::CHAN_W-1:0] i_dst_blue = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_write_pixel;
    logic [sabc_pkg::COORD_W-1:0] o_canvas_col;
    logic [sabc_pkg::COORD_W-1:0] o_canvas_row;
    logic [sabc_pkg::CHAN_W-1:0] o_out_red;
    logic [sabc_pkg::CHAN_W-1:0] o_out_green;
    logic [sabc_pkg::CHAN_W-1:0] o_out_blue;

    t_blend_result due_pixels [$];       // predicted results, oldest first
    sabc_pkg::t_cfg cfg_now = CFG_DEFAULT;  // shadow of the block's registers
    int idle_pct = 30;                   // chance per cycle that either side idles
    int mismatches = 0;

    sprite_alpha_blend_clip_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sprite_col  (i_sprite_col),
        .i_sprite_row  (i_sprite_row),
        .i_src_red     (i_src_red),
        .i_src_green   (i_src_green),
        .i_src_blue    (i_src_blue),
        .i_src_alpha   (i_src_alpha),
        .i_dst_red     (i_dst_red),
        .i_dst_green   (i_dst_green),
        .i_dst_blue    (i_dst_blue),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_write_pixel (o_write_pixel),
        .o_canvas_col  (o_canvas_col),
        .o_canvas_row  (o_canvas_row),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Source-over mix of one channel, rounded to nearest.
    function automatic logic [sabc_pkg::CHAN_W-1:0] mix_channel(input int s, input int d,
                                                                input int a);
        int mixed;
        mixed = (s * a + d * (255 - a) + 127) / 255;
        return mixed[sabc_pkg::CHAN_W-1:0];
    endfunction

    // Work out what the block must produce for one pixel under a given setup.
    function automatic t_blend_result predict_blend(input sabc_pkg::t_cfg c,
                                                    input t_sprite_pixel px);
        int cx;
        int cy;
        int w;
        int h;
        int op;
        int a;
        t_blend_result res;
        cx = $signed(c.origin_x) + int'(px.col);
        cy = $signed(c.origin_y) + int'(px.row);
        w = (int'(c.canvas_width) > sabc_pkg::MAX_DIM) ?
            sabc_pkg::MAX_DIM : int'(c.canvas_width);
        h = (int'(c.canvas_height) > sabc_pkg::MAX_DIM) ?
            sabc_pkg::MAX_DIM : int'(c.canvas_height);
        op = (c.opacity_percent > sabc_pkg::OPACITY_MAX) ? 100 : int'(c.opacity_percent);
        a = (int'(px.src_alpha) * op + 50) / 100;
        res = '0;
        // clipped or transparent pixels leave every field at zero
        if (cx >= 0 && cy >= 0 && cx < w && cy < h && a != 0) begin
            res.write_pixel = 1'b1;
            res.col = cx[sabc_pkg::COORD_W-1:0];
            res.row = cy[sabc_pkg::COORD_W-1:0];
            if (a >= 255) begin
                res.red = px.src_red;
                res.green = px.src_green;
                res.blue = px.src_blue;
            end else begin
                res.red = mix_channel(int'(px.src_red), int'(px.dst_red), a);
                res.green = mix_channel(int'(px.src_green), int'(px.dst_green), a);
                res.blue = mix_channel(int'(px.src_blue), int'(px.dst_blue), a);
            end
        end
        return res;
    endfunction

    // Pick a canvas setup, leaning toward sizes and origins that keep many pixels
    // on the canvas, with the extremes and out-of-range values mixed in.
    function automatic sabc_pkg::t_cfg random_canvas_setup();
        sabc_pkg::t_cfg c;
        logic [sabc_pkg::DIM_W-1:0] pick [2];
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(0, 5))
                0: pick[i] = sabc_pkg::DIM_W'($urandom);
                1: pick[i] = $urandom_range(0, 1) ? 11'h400 : 11'h3FF;
                default: pick[i] = sabc_pkg::DIM_W'(int'($urandom_range(0, 64)) - 32);
            endcase
        end
        c.origin_x = pick[0];
        c.origin_y = pick[1];
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(0, 9))
                0: pick[i] = ($urandom_range(0, 3) == 0) ?
                             '0 : sabc_pkg::DIM_W'($urandom_range(1025, 2047));
                1: pick[i] = sabc_pkg::DIM_MAX;
                2, 3: pick[i] = sabc_pkg::DIM_W'($urandom_range(1, 8));
                default: pick[i] = sabc_pkg::DIM_W'($urandom_range(1, sabc_pkg::MAX_DIM));
            endcase
        end
        c.canvas_width = pick[0];
        c.canvas_height = pick[1];
        case ($urandom_range(0, 7))
            0: c.opacity_percent = sabc_pkg::OPA_W'($urandom_range(101, 127));
            1: c.opacity_percent = sabc_pkg::OPACITY_MAX;
            2: c.opacity_percent = '0;
            default: c.opacity_percent = sabc_pkg::OPA_W'($urandom_range(1, 99));
        endcase
        return c;
    endfunction

    // Random pixel: mostly aimed at the canvas edges and interior, sometimes anywhere.
    function automatic t_sprite_pixel random_pixel(input sabc_pkg::t_cfg c);
        t_sprite_pixel px;
        int w;
        int h;
        int target;
        px = t_sprite_pixel'({$urandom, $urandom, $urandom});
        w = (int'(c.canvas_width) > sabc_pkg::MAX_DIM) ?
            sabc_pkg::MAX_DIM : int'(c.canvas_width);
        h = (int'(c.canvas_height) > sabc_pkg::MAX_DIM) ?
            sabc_pkg::MAX_DIM : int'(c.canvas_height);
        if ($urandom_range(0, 9) < 7) begin
            target = int'($urandom_range(0, w + 7)) - 4 - $signed(c.origin_x);
            if (target >= 0 && target < sabc_pkg::MAX_DIM) begin
                px.col = sabc_pkg::COORD_W'(target);
            end
            target = int'($urandom_range(0, h + 7)) - 4 - $signed(c.origin_y);
            if (target >= 0 && target < sabc_pkg::MAX_DIM) begin
                px.row = sabc_pkg::COORD_W'(target);
            end
        end
        case ($urandom_range(0, 9))
            0, 1: px.src_alpha = sabc_pkg::ALPHA_FULL;
            2: px.src_alpha = '0;
            3: px.src_alpha = sabc_pkg::CHAN_W'($urandom_range(1, 3));
            default: ;
        endcase
        return px;
    endfunction

    // Write one register over the config port, read it back and compare the
    // implemented bits.
    task automatic write_reg(input logic [2:0] reg_code,
                             input logic [sabc_pkg::DATA_W-1:0] value, input int bits);
        logic [sabc_pkg::DATA_W-1:0] mask;
        mask = (sabc_pkg::DATA_W'(1) << bits) - sabc_pkg::DATA_W'(1);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_code, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        do begin
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
        end while (!pready);
        if ((prdata & mask) != (value & mask)) begin
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, reg_code, value & mask, prdata & mask);
            mismatches++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the pipeline, then load a full canvas setup.
    task automatic load_config(input sabc_pkg::t_cfg c);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(sabc_pkg::REG_ORIGIN_X, sabc_pkg::DATA_W'($signed(c.origin_x)),
                  sabc_pkg::DIM_W);
        write_reg(sabc_pkg::REG_ORIGIN_Y, sabc_pkg::DATA_W'($signed(c.origin_y)),
                  sabc_pkg::DIM_W);
        write_reg(sabc_pkg::REG_CANVAS_WIDTH, sabc_pkg::DATA_W'(c.canvas_width),
                  sabc_pkg::DIM_W);
        write_reg(sabc_pkg::REG_CANVAS_HEIGHT, sabc_pkg::DATA_W'(c.canvas_height),
                  sabc_pkg::DIM_W);
        write_reg(sabc_pkg::REG_OPACITY, sabc_pkg::DATA_W'(c.opacity_percent),
                  sabc_pkg::OPA_W);
        cfg_now = c;
    endtask

    // Offer one pixel, idling first at random; hold it steady until accepted, then
    // record the result it must produce.
    task automatic present_pixel(input t_sprite_pixel px, input logic typed,
                                 input t_blend_result want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sprite_col <= px.col;
        i_sprite_row <= px.row;
        i_src_red <= px.src_red;
        i_src_green <= px.src_green;
        i_src_blue <= px.src_blue;
        i_src_alpha <= px.src_alpha;
        i_dst_red <= px.dst_red;
        i_dst_green <= px.dst_green;
        i_dst_blue <= px.dst_blue;
        do @(posedge i_clk); while (o_stall);
        due_pixels.push_back(typed ? want : predict_blend(cfg_now, px));
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Receiver: stall at random on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // Result checker: compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_blend_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_pixels.size() == 0) begin
                $display("%0t: result with none expected, actual write %0d col %0d row %0d",
                         $time, o_write_pixel, o_canvas_col, o_canvas_row);
                mismatches++;
            end else begin
                want = due_pixels.pop_front();
                check_field("write_pixel", 32'(want.write_pixel), 32'(o_write_pixel));
                check_field("canvas_col", 32'(want.col), 32'(o_canvas_col));
                check_field("canvas_row", 32'(want.row), 32'(o_canvas_row));
                check_field("out_red", 32'(want.red), 32'(o_out_red));
                check_field("out_green", 32'(want.green), 32'(o_out_green));
                check_field("out_blue", 32'(want.blue), 32'(o_out_blue));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin
        sabc_pkg::t_cfg phase_cfg;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; reload registers whenever a row's setup changes.
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (DIRECTED_PLAN[i].setup != cfg_now) load_config(DIRECTED_PLAN[i].setup);
            present_pixel(DIRECTED_PLAN[i].px, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end

        // Random phases, each under a fresh canvas setup; one phase runs flat out.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            phase_cfg = random_canvas_setup();
            load_config(phase_cfg);
            idle_pct = (p == CALM_PHASE) ? 0 : 30;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                present_pixel(random_pixel(cfg_now), 1'b0, NO_WRITE);
            end
        end

        // Drop valid, let everything outstanding arrive, then give the verdict.
        @(negedge i_clk);
        i_valid <= 1'b0;
        idle_pct = 30;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
